// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the stiffness block.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/btdb_pkg.sv =====
// Shared constants, types and fixed-point helpers for the stiffness block.
// Depends on nothing; imported by btdb_stiffness_block.
package btdb_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_W       = 48;
    localparam int NDIR        = 3;
    localparam int MAT_DIM     = 6;
    localparam int MAT_SIZE    = MAT_DIM * MAT_DIM;
    localparam int MAT_IDX_W   = $clog2(MAT_SIZE);
    localparam int SLOT_W      = $clog2(MAT_DIM);
    localparam int P1_W        = 2 * VALUE_WIDTH;
    localparam int PROD_W      = OUT_W + VALUE_WIDTH;
    localparam int SAT_W       = PROD_W + 2;
    localparam int SPLIT       = OUT_W / 2;
    localparam int PL_W        = SPLIT + 1 + VALUE_WIDTH;
    localparam int PH_W        = OUT_W - SPLIT + VALUE_WIDTH;
    localparam int NSTAGE      = 8;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef logic signed [VALUE_WIDTH-1:0] val_t;
    typedef logic signed [OUT_W-1:0]       out_t;
    typedef logic signed [P1_W-1:0]        p1_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SAT_W-1:0]       sat_t;
    typedef logic signed [PL_W-1:0]        pl_t;
    typedef logic signed [PH_W-1:0]        ph_t;
    typedef logic [SLOT_W-1:0]             slot_t;
    typedef logic [MAT_IDX_W-1:0]          mat_idx_t;

    // Voigt slot for a pair of directions, order xx,yy,zz,yz,xz,xy.
    localparam slot_t VOIGT [NDIR][NDIR] = '{
        '{slot_t'(0), slot_t'(5), slot_t'(4)},
        '{slot_t'(5), slot_t'(1), slot_t'(3)},
        '{slot_t'(4), slot_t'(3), slot_t'(2)}
    };

    localparam sat_t  SAT_HI      = {{(SAT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam sat_t  SAT_LO      = {{(SAT_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    localparam out_t  OUT_HI      = {1'b0, {(OUT_W-1){1'b1}}};
    localparam out_t  OUT_LO      = {1'b1, {(OUT_W-1){1'b0}}};
    localparam prod_t RND_HALF    = prod_t'(1) <<< (FRAC_BITS - 1);
    localparam prod_t RND_HALF_M1 = RND_HALF - prod_t'(1);

    // Address of the material entry that row direction k, gradient component c
    // and material column m select.
    function automatic mat_idx_t mat_addr(input int k, input int c, input int m);
        return MAT_IDX_W'(int'(VOIGT[k][c]) * MAT_DIM + m);
    endfunction

    // Drops the fraction bits, rounding half away from zero.
    function automatic sat_t round_frac(input prod_t p);
        prod_t bias;
        bias = p[PROD_W-1] ? RND_HALF_M1 : RND_HALF;
        return SAT_W'((p + bias) >>> FRAC_BITS);
    endfunction

    // Clamps to the signed output range.
    function automatic out_t sat_out(input sat_t v);
        out_t r;
        if (v > SAT_HI) begin
            r = OUT_HI;
        end else if (v < SAT_LO) begin
            r = OUT_LO;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/btdb_stiffness_block.sv =====
// Stiffness block B_l^T D B_r for one node pair of a 3-D solid element.
// Depends on btdb_pkg and on assert_macros.svh.
//
// Usage: one request channel (s_valid/s_ready) and one result channel
// (m_valid/m_ready). A request with s_operation = OP_LOAD stores s_mat_value
// into material entry s_mat_index (row*6+col, Voigt order); indices above 35
// are dropped. Load requests never produce a result. A request with
// s_operation = OP_COMPUTE takes the left and right gradients and produces
// the nine Q32.16 entries of the 3x3 block, saturated, on the m_k_* ports.
// Throughput is one request per cycle. A compute result appears on m_valid
// after its request is accepted and has passed eight registers:
// an input register, three stages (multiply, round, sum) for l^T D, three
// stages (split multiply, recombine, round) for the product with r, and the
// output register, which also holds the final sum.
// A load is written into the material store in the cycle after acceptance, so
// it is seen by every compute request accepted after it.
// Reset clears the material store to zero and empties the pipeline.
// When the receiver stalls, results stay on the output register; stages
// behind it keep moving until they fill, empty slots are squeezed out, and
// s_ready falls only when every stage holds a request.
`include "assert_macros.svh"

module btdb_stiffness_block import btdb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_operation,
    input  mat_idx_t s_mat_index,
    input  val_t     s_mat_value,
    input  val_t     s_left_dx,
    input  val_t     s_left_dy,
    input  val_t     s_left_dz,
    input  val_t     s_right_dx,
    input  val_t     s_right_dy,
    input  val_t     s_right_dz,
    output logic     m_valid,
    input  logic     m_ready,
    output out_t     m_k_xx,
    output out_t     m_k_xy,
    output out_t     m_k_xz,
    output out_t     m_k_yx,
    output out_t     m_k_yy,
    output out_t     m_k_yz,
    output out_t     m_k_zx,
    output out_t     m_k_zy,
    output out_t     m_k_zz
);

    // Material matrix, one register per entry.
    val_t d_reg [MAT_SIZE];

    // One valid bit per stage; free[i] says stage i may load this cycle.
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_next;
    logic [NSTAGE-1:0] free;
    logic              mat_we;

    // Stage 0: registered request.
    logic     op0_reg;
    mat_idx_t idx0_reg;
    val_t     mval0_reg;
    val_t     l0_reg [NDIR];
    val_t     r0_reg [NDIR];

    // Stages 1 to 3: a = l^T D, one product per gradient component.
    p1_t  p1_reg  [NDIR][MAT_DIM][NDIR];
    p1_t  p1_next [NDIR][MAT_DIM][NDIR];
    out_t q2_reg  [NDIR][MAT_DIM][NDIR];
    out_t q2_next [NDIR][MAT_DIM][NDIR];
    out_t a3_reg  [NDIR][MAT_DIM];
    out_t a3_next [NDIR][MAT_DIM];
    val_t r1_reg  [NDIR];
    val_t r2_reg  [NDIR];
    val_t r3_reg  [NDIR];

    // Stages 4 to 7: K = a B_r, the 48-bit operand split into two halves.
    pl_t   pl4_reg  [NDIR][NDIR][NDIR];
    pl_t   pl4_next [NDIR][NDIR][NDIR];
    ph_t   ph4_reg  [NDIR][NDIR][NDIR];
    ph_t   ph4_next [NDIR][NDIR][NDIR];
    prod_t p5_reg   [NDIR][NDIR][NDIR];
    prod_t p5_next  [NDIR][NDIR][NDIR];
    out_t  q6_reg   [NDIR][NDIR][NDIR];
    out_t  q6_next  [NDIR][NDIR][NDIR];
    out_t  k7_reg   [NDIR][NDIR];
    out_t  k7_next  [NDIR][NDIR];

    // ------------------------------------------------------------------
    // Flow control. A stage refills when it is empty or its item moves on.
    // A load in stage 0 always leaves, since it only writes the store.
    // ------------------------------------------------------------------
    always_comb begin
        free[NSTAGE-1] = !v_reg[NSTAGE-1] || m_ready;
        for (int i = NSTAGE - 2; i >= 1; i--) begin
            free[i] = !v_reg[i] || free[i+1];
        end
        free[0] = !v_reg[0] || (op0_reg == OP_LOAD) || free[1];
    end

    always_comb begin
        v_next[0] = free[0] ? s_valid : v_reg[0];
        v_next[1] = free[1] ? (v_reg[0] && (op0_reg == OP_COMPUTE)) : v_reg[1];
        for (int i = 2; i < NSTAGE; i++) begin
            v_next[i] = free[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign mat_we  = v_reg[0] && (op0_reg == OP_LOAD) &&
                     (idx0_reg < MAT_IDX_W'(MAT_SIZE));
    assign s_ready = free[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
            for (int i = 0; i < MAT_SIZE; i++) begin
                d_reg[i] <= '0;
            end
        end else begin
            v_reg <= v_next;
            if (mat_we) begin
                d_reg[idx0_reg] <= mval0_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath next values.
    // ------------------------------------------------------------------
    // Stage 1: l_c times the material entry of Voigt row V(k,c), column m.
    always_comb begin
        for (int k = 0; k < NDIR; k++) begin
            for (int m = 0; m < MAT_DIM; m++) begin
                for (int c = 0; c < NDIR; c++) begin
                    p1_next[k][m][c] = p1_t'(l0_reg[c]) *
                                       p1_t'(d_reg[mat_addr(k, c, m)]);
                end
            end
        end
    end

    // Stage 2: round each product back to the fixed-point grid and clamp.
    always_comb begin
        for (int k = 0; k < NDIR; k++) begin
            for (int m = 0; m < MAT_DIM; m++) begin
                for (int c = 0; c < NDIR; c++) begin
                    q2_next[k][m][c] = sat_out(round_frac(prod_t'(p1_reg[k][m][c])));
                end
            end
        end
    end

    // Stage 3: sum the three terms of each entry of a.
    always_comb begin
        for (int k = 0; k < NDIR; k++) begin
            for (int m = 0; m < MAT_DIM; m++) begin
                a3_next[k][m] = sat_out(sat_t'(q2_reg[k][m][0]) +
                                        sat_t'(q2_reg[k][m][1]) +
                                        sat_t'(q2_reg[k][m][2]));
            end
        end
    end

    // Stage 4: a(k, V(j,c)) times r_c as two partial products, low half unsigned.
    always_comb begin
        out_t sel;
        sel = '0;
        for (int k = 0; k < NDIR; k++) begin
            for (int j = 0; j < NDIR; j++) begin
                for (int c = 0; c < NDIR; c++) begin
                    sel = a3_reg[k][VOIGT[j][c]];
                    pl4_next[k][j][c] = pl_t'($signed({1'b0, sel[SPLIT-1:0]})) *
                                        pl_t'(r3_reg[c]);
                    ph4_next[k][j][c] = ph_t'($signed(sel[OUT_W-1:SPLIT])) *
                                        ph_t'(r3_reg[c]);
                end
            end
        end
    end

    // Stage 5: recombine the partial products into the full product.
    always_comb begin
        for (int k = 0; k < NDIR; k++) begin
            for (int j = 0; j < NDIR; j++) begin
                for (int c = 0; c < NDIR; c++) begin
                    p5_next[k][j][c] = (prod_t'(ph4_reg[k][j][c]) <<< SPLIT) +
                                       prod_t'(pl4_reg[k][j][c]);
                end
            end
        end
    end

    // Stage 6: round and clamp each product.
    always_comb begin
        for (int k = 0; k < NDIR; k++) begin
            for (int j = 0; j < NDIR; j++) begin
                for (int c = 0; c < NDIR; c++) begin
                    q6_next[k][j][c] = sat_out(round_frac(p5_reg[k][j][c]));
                end
            end
        end
    end

    // Stage 7: sum the three terms of each block entry.
    always_comb begin
        for (int k = 0; k < NDIR; k++) begin
            for (int j = 0; j < NDIR; j++) begin
                k7_next[k][j] = sat_out(sat_t'(q6_reg[k][j][0]) +
                                        sat_t'(q6_reg[k][j][1]) +
                                        sat_t'(q6_reg[k][j][2]));
            end
        end
    end

    // Payload registers move with their valid bits and need no reset.
    always_ff @(posedge aclk) begin
        if (free[0]) begin
            op0_reg   <= s_operation;
            idx0_reg  <= s_mat_index;
            mval0_reg <= s_mat_value;
            l0_reg    <= '{s_left_dx, s_left_dy, s_left_dz};
            r0_reg    <= '{s_right_dx, s_right_dy, s_right_dz};
        end
        if (free[1]) begin
            p1_reg <= p1_next;
            r1_reg <= r0_reg;
        end
        if (free[2]) begin
            q2_reg <= q2_next;
            r2_reg <= r1_reg;
        end
        if (free[3]) begin
            a3_reg <= a3_next;
            r3_reg <= r2_reg;
        end
        if (free[4]) begin
            pl4_reg <= pl4_next;
            ph4_reg <= ph4_next;
        end
        if (free[5]) begin
            p5_reg <= p5_next;
        end
        if (free[6]) begin
            q6_reg <= q6_next;
        end
        if (free[7]) begin
            k7_reg <= k7_next;
        end
    end

    assign m_valid = v_reg[NSTAGE-1];
    assign m_k_xx  = k7_reg[0][0];
    assign m_k_xy  = k7_reg[0][1];
    assign m_k_xz  = k7_reg[0][2];
    assign m_k_yx  = k7_reg[1][0];
    assign m_k_yy  = k7_reg[1][1];
    assign m_k_yz  = k7_reg[1][2];
    assign m_k_zx  = k7_reg[2][0];
    assign m_k_zy  = k7_reg[2][1];
    assign m_k_zz  = k7_reg[2][2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_empty_in_ready, !v_reg[0], s_ready,
        "request refused with an empty input stage")
    `ASSERT_IMPLIES(a_full_stall, (&v_reg[NSTAGE-1:1]) && v_reg[0] &&
        (op0_reg == OP_COMPUTE) && !m_ready, !s_ready,
        "request taken while every stage is full and the output stalls")
    `ASSERT_NEXT(a_load_no_result, mat_we && free[1], !v_reg[1],
        "a material load entered the compute pipeline")
    `ASSERT_IMPLIES(a_out_from_stage6, $rose(v_reg[NSTAGE-1]), $past(v_reg[NSTAGE-2]),
        "result appeared without an item in the last rounding stage")

endmodule
